### rtl/core/scrr_pkg.sv
package scrr_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int SLOT_COUNT = 7;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int HEAD_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W = $clog2(SLOT_COUNT * FIFO_DEPTH);
  localparam int RAM_DEPTH = SLOT_COUNT * FIFO_DEPTH;

  localparam int ID_W   = 10;
  localparam int SIZE_W = 8;
  localparam int QNT_W  = 16;
  localparam int TIME_W = 24;
  localparam int TURN_W = 25;
  localparam int BUSY_W = 3;

  // size class limits in MB
  localparam logic [SIZE_W-1:0] SIZE_CLASS0 = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_CLASS1 = SIZE_W'(4);
  localparam logic [SIZE_W-1:0] SIZE_CLASS2 = SIZE_W'(6);
  localparam logic [SIZE_W-1:0] SIZE_CLASS3 = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] SIZE_CLASS5 = SIZE_W'(12);
  localparam logic [SIZE_W-1:0] SIZE_OVER   = SIZE_W'(16);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_QUANTUM = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [QNT_W-1:0]  quanta;
    logic [TIME_W-1:0] start;
  } job_entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    job_entry_t        data;
  } ram_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_SCAN,
    ST_SERVE,
    ST_EMIT
  } sched_state_t;

  function automatic logic [ADDR_W-1:0] fifo_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [HEAD_W-1:0] pos);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(slot) * ADDR_W'(FIFO_DEPTH);
    return base + ADDR_W'(pos);
  endfunction

endpackage

### rtl/core/scrr_job_ram.sv
module scrr_job_ram
  import scrr_pkg::*;
(
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output job_entry_t        rd_data
);

  job_entry_t mem [RAM_DEPTH];
  job_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/size_class_round_robin_scheduler_core.sv
// Seven-slot size-class scheduler. Each input word either enqueues a job
// (mode 0) or runs one service quantum (mode 1); every input word yields
// exactly one result word. An enqueue passes from the ENQ state to EMIT,
// where its result is registered. A quantum's round-robin search checks one
// slot per cycle starting at the service pointer (up to 7 slots) while the
// head of the slot's waiting queue is read from the single-port-read job
// memory; the slot is then served. A quantum with no busy slot skips both.
// One item is in work at a time; the result register lets the next item in
// once the result is loaded, even if the output side is stalled. Queued jobs
// live in one memory of SLOT_COUNT x FIFO_DEPTH entries; no clearing pass
// is needed after reset.
module size_class_round_robin_scheduler_core
  import scrr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_mode,
  input  logic [ID_W-1:0]          in_job_id,
  input  logic [SIZE_W-1:0]        in_job_size_mb,
  input  logic [QNT_W-1:0]         in_service_quanta,
  input  logic [TIME_W-1:0]        in_start_time,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_completed,
  output logic [ID_W-1:0]          out_done_job_id,
  output logic [TIME_W-1:0]        out_finish_time,
  output logic signed [TURN_W-1:0] out_turnaround,
  output logic                     out_oversize,
  output logic                     out_queue_overflow,
  output logic                     out_all_idle,
  output logic [BUSY_W-1:0]        out_busy_slots
);

  sched_state_t state_r, state_nxt;

  // captured input word
  logic              mode_r;
  logic [ID_W-1:0]   id_r;
  logic [SIZE_W-1:0] size_r;
  logic [QNT_W-1:0]  quanta_r;
  logic [TIME_W-1:0] start_r;

  // per-slot state
  logic [SLOT_COUNT-1:0] slot_busy_r;
  logic [ID_W-1:0]       slot_job_r   [SLOT_COUNT];
  logic [QNT_W-1:0]      slot_rem_r   [SLOT_COUNT];
  logic [TIME_W-1:0]     slot_start_r [SLOT_COUNT];
  logic [HEAD_W-1:0]     fifo_head_r  [SLOT_COUNT];
  logic [CNT_W-1:0]      fifo_count_r [SLOT_COUNT];

  logic [SLOT_W-1:0] service_ptr_r;
  logic [TIME_W-1:0] qclock_r;
  logic              toggle_r;
  logic [BUSY_W-1:0] busy_total_r;
  logic [SLOT_W-1:0] scan_r;

  // pending result
  logic              res_completed_r;
  logic [ID_W-1:0]   res_id_r;
  logic [TIME_W-1:0] res_fin_r;
  logic [TURN_W-1:0] res_turn_r;
  logic              res_over_r;
  logic              res_ovf_r;

  logic              out_valid_r;
  logic              out_completed_r;
  logic [ID_W-1:0]   out_id_r;
  logic [TIME_W-1:0] out_fin_r;
  logic [TURN_W-1:0] out_turn_r;
  logic              out_over_r;
  logic              out_ovf_r;
  logic [BUSY_W-1:0] out_busy_r;

  logic in_acc;
  logic out_load;

  ram_wr_t    ram_wr;
  job_entry_t ram_rd;

  // enqueue slot selection
  logic [SLOT_W-1:0] enq_slot;
  logic              enq_eight;
  logic [QNT_W-1:0]  enq_quanta;
  logic [CNT_W:0]    tail_sum;
  logic [HEAD_W-1:0] tail_pos;

  // service datapath
  logic [QNT_W-1:0]  rem_dec;
  logic [HEAD_W-1:0] head_next;
  logic [TURN_W-1:0] turn_val;

  always_comb begin
    enq_eight = 1'b0;
    if (size_r <= SIZE_CLASS0) begin
      enq_slot = SLOT_W'(0);
    end else if (size_r <= SIZE_CLASS1) begin
      enq_slot = SLOT_W'(1);
    end else if (size_r <= SIZE_CLASS2) begin
      enq_slot = SLOT_W'(2);
    end else if (size_r <= SIZE_CLASS3) begin
      enq_slot  = toggle_r ? SLOT_W'(4) : SLOT_W'(3);
      enq_eight = 1'b1;
    end else if (size_r <= SIZE_CLASS5) begin
      enq_slot = SLOT_W'(5);
    end else begin
      enq_slot = SLOT_W'(6);
    end
  end

  assign enq_quanta = (quanta_r == '0) ? QNT_W'(1) : quanta_r;

  // tail = (head + count) mod depth, sum stays below twice the depth
  assign tail_sum = (CNT_W + 1)'(fifo_head_r[enq_slot]) + (CNT_W + 1)'(fifo_count_r[enq_slot]);
  assign tail_pos = (tail_sum >= (CNT_W + 1)'(FIFO_DEPTH))
                  ? HEAD_W'(tail_sum - (CNT_W + 1)'(FIFO_DEPTH))
                  : HEAD_W'(tail_sum);

  assign rem_dec   = slot_rem_r[scan_r] - QNT_W'(1);
  assign head_next = (fifo_head_r[scan_r] == HEAD_W'(FIFO_DEPTH - 1))
                   ? '0 : fifo_head_r[scan_r] + HEAD_W'(1);
  assign turn_val  = {1'b0, qclock_r} - {1'b0, slot_start_r[scan_r]};

  always_comb begin
    ram_wr.en   = (state_r == ST_ENQ) && slot_busy_r[enq_slot]
                  && (fifo_count_r[enq_slot] != CNT_W'(FIFO_DEPTH));
    ram_wr.addr = fifo_addr(enq_slot, tail_pos);
    ram_wr.data = '{job_id: id_r, quanta: enq_quanta, start: start_r};
  end

  scrr_job_ram u_job_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (fifo_addr(scan_r, fifo_head_r[scan_r])),
    .rd_data (ram_rd)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_ENQUEUE) begin
            state_nxt = ST_ENQ;
          end else if (busy_total_r == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_ENQ:   state_nxt = ST_EMIT;
      ST_SCAN: begin
        // the memory read of this slot's queue head is in flight
        if (slot_busy_r[scan_r]) begin
          state_nxt = ST_SERVE;
        end
      end
      ST_SERVE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // input capture and pending result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r          <= in_mode;
      id_r            <= in_job_id;
      size_r          <= in_job_size_mb;
      quanta_r        <= in_service_quanta;
      start_r         <= in_start_time;
      res_completed_r <= 1'b0;
      res_id_r        <= '0;
      res_fin_r       <= '0;
      res_turn_r      <= '0;
      res_over_r      <= 1'b0;
      res_ovf_r       <= 1'b0;
    end
    if (state_r == ST_ENQ) begin
      res_over_r <= (size_r > SIZE_OVER);
      res_ovf_r  <= slot_busy_r[enq_slot]
                    && (fifo_count_r[enq_slot] == CNT_W'(FIFO_DEPTH));
    end
    if ((state_r == ST_SERVE) && (rem_dec == '0)) begin
      res_completed_r <= 1'b1;
      res_id_r        <= slot_job_r[scan_r];
      res_fin_r       <= qclock_r;
      res_turn_r      <= turn_val;
    end
  end

  // slot payload, no reset
  always_ff @(posedge clk) begin
    if ((state_r == ST_ENQ) && !slot_busy_r[enq_slot]) begin
      slot_job_r[enq_slot]   <= id_r;
      slot_rem_r[enq_slot]   <= enq_quanta;
      slot_start_r[enq_slot] <= start_r;
    end
    if (state_r == ST_SERVE) begin
      if ((rem_dec == '0) && (fifo_count_r[scan_r] != '0)) begin
        slot_job_r[scan_r]   <= ram_rd.job_id;
        slot_rem_r[scan_r]   <= ram_rd.quanta;
        slot_start_r[scan_r] <= ram_rd.start;
      end else begin
        slot_rem_r[scan_r] <= rem_dec;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_busy_r   <= '0;
      service_ptr_r <= '0;
      qclock_r      <= '0;
      toggle_r      <= 1'b0;
      busy_total_r  <= '0;
      scan_r        <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        fifo_head_r[i]  <= '0;
        fifo_count_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        scan_r <= service_ptr_r;
      end
      if (state_r == ST_ENQ) begin
        if (enq_eight) begin
          toggle_r <= !toggle_r;
        end
        if (!slot_busy_r[enq_slot]) begin
          slot_busy_r[enq_slot] <= 1'b1;
          busy_total_r          <= busy_total_r + BUSY_W'(1);
        end else if (ram_wr.en) begin
          fifo_count_r[enq_slot] <= fifo_count_r[enq_slot] + CNT_W'(1);
        end
      end
      if ((state_r == ST_SCAN) && !slot_busy_r[scan_r]) begin
        scan_r <= (scan_r == SLOT_LAST) ? '0 : scan_r + SLOT_W'(1);
      end
      if (state_r == ST_SERVE) begin
        if (rem_dec == '0) begin
          if (fifo_count_r[scan_r] != '0) begin
            fifo_head_r[scan_r]  <= head_next;
            fifo_count_r[scan_r] <= fifo_count_r[scan_r] - CNT_W'(1);
          end else begin
            slot_busy_r[scan_r] <= 1'b0;
            busy_total_r        <= busy_total_r - BUSY_W'(1);
          end
        end
        service_ptr_r <= (scan_r == SLOT_LAST) ? '0 : scan_r + SLOT_W'(1);
        qclock_r      <= qclock_r + TIME_W'(1);
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_completed_r <= res_completed_r;
      out_id_r        <= res_id_r;
      out_fin_r       <= res_fin_r;
      out_turn_r      <= res_turn_r;
      out_over_r      <= res_over_r && (mode_r == MODE_ENQUEUE);
      out_ovf_r       <= res_ovf_r;
      out_busy_r      <= busy_total_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_completed      = out_completed_r;
  assign out_done_job_id    = out_id_r;
  assign out_finish_time    = out_fin_r;
  assign out_turnaround     = signed'(out_turn_r);
  assign out_oversize       = out_over_r;
  assign out_queue_overflow = out_ovf_r;
  assign out_all_idle       = (out_busy_r == '0);
  assign out_busy_slots     = out_busy_r;

endmodule

### rtl/core/scrr_checker.sv
module scrr_checker
  import scrr_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_completed,
  input logic [ID_W-1:0]          out_done_job_id,
  input logic signed [TURN_W-1:0] out_turnaround,
  input logic                     out_oversize,
  input logic                     out_queue_overflow,
  input logic                     out_all_idle,
  input logic [BUSY_W-1:0]        out_busy_slots
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_done_job_id)
      && $stable(out_turnaround) && $stable(out_completed))
    else $error("stalled result word changed");

  // a finished quantum never carries enqueue flags
  a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_completed |-> !out_oversize && !out_queue_overflow)
    else $error("completion word carries enqueue flags");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_all_idle == (out_busy_slots == '0)))
    else $error("all_idle disagrees with busy_slots");

  // an overflow means the target slot was occupied
  a_ovf_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_overflow |-> !out_completed && !out_all_idle)
    else $error("overflow reported with no busy slot");

  // one word in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in work");

endmodule

bind size_class_round_robin_scheduler_core scrr_checker u_scrr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_completed      (out_completed),
  .out_done_job_id    (out_done_job_id),
  .out_turnaround     (out_turnaround),
  .out_oversize       (out_oversize),
  .out_queue_overflow (out_queue_overflow),
  .out_all_idle       (out_all_idle),
  .out_busy_slots     (out_busy_slots)
);
